>>> hdl/nrs_pkg.sv
// ----------------------------------------------------------------------------
// nrs_pkg
// Shared types, constants and elaboration-time Gold sequence helpers for the
// NB-IoT NRS pilot generator.
// ----------------------------------------------------------------------------
package nrs_pkg;

  localparam int unsigned CELL_ID_W           = 9;
  localparam int unsigned SLOT_W              = 5;
  localparam int unsigned SEED_W              = 31;
  localparam int unsigned SEED_SCALE_W        = 10;   // c_init scale of 1024
  localparam int unsigned SYM_BASE            = 13;   // 7 + OFDM symbol 5 + 1
  localparam int unsigned GOLD_OFFSET         = 1600;
  localparam int unsigned MAX_RESOURCE_BLOCKS = 110;
  localparam int unsigned QUEUE_DEPTH         = 4;

  // Steps from the seed to c(2*(MAX_RESOURCE_BLOCKS-1))
  localparam int unsigned GOLD_SKIP = GOLD_OFFSET + 2 * (MAX_RESOURCE_BLOCKS - 1);

  typedef struct packed {
    logic [SLOT_W-1:0] slot_number;
    logic              ref_symbol;
  } in_t;

  typedef struct packed {
    logic              pilot_index;
    logic              real_negative;
    logic              imag_negative;
    logic [SLOT_W-1:0] slot_echo;
    logic              symbol_echo;
    logic              last;
  } out_t;

  // Seeded request between front and back
  typedef struct packed {
    logic [SLOT_W-1:0] slot_number;
    logic              ref_symbol;
    logic [SEED_W-1:0] seed;
  } job_t;

  function automatic logic [SEED_W-1:0] x1_step(logic [SEED_W-1:0] x);
    return {x[3] ^ x[0], x[SEED_W-1:1]};
  endfunction

  function automatic logic [SEED_W-1:0] x2_step(logic [SEED_W-1:0] x);
    return {x[3] ^ x[2] ^ x[1] ^ x[0], x[SEED_W-1:1]};
  endfunction

  // x1 is seeded with 1, so its output bits are fixed: bit k is x1(skip+k)
  function automatic logic [3:0] x1_tail(int unsigned skip);
    logic [SEED_W-1:0] x;
    logic [3:0]        b;
    x = SEED_W'(1);
    b = '0;
    for (int unsigned n = 0; n < skip; n++) x = x1_step(x);
    for (int unsigned k = 0; k < 4; k++) begin
      b[k] = x[0];
      x    = x1_step(x);
    end
    return b;
  endfunction

  // x2 is linear in the seed: output bit after `steps` steps is the parity
  // of seed & mask, where mask bit j is the response to seed bit j alone
  function automatic logic [SEED_W-1:0] x2_mask(int unsigned steps);
    logic [SEED_W-1:0] x;
    logic [SEED_W-1:0] m;
    m = '0;
    for (int unsigned j = 0; j < SEED_W; j++) begin
      x = SEED_W'(1) << j;
      for (int unsigned n = 0; n < steps; n++) x = x2_step(x);
      m[j] = x[0];
    end
    return m;
  endfunction

endpackage

>>> hdl/nrs_front.sv
// ----------------------------------------------------------------------------
// nrs_front
// Request intake: forms the Gold sequence seed c_init and registers it.
// ----------------------------------------------------------------------------
module nrs_front import nrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [CELL_ID_W-1:0] cell_id,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 job_valid,
  input  logic                 job_ready,
  output job_t                 job
);

  localparam int unsigned A_W    = 8;   // 7*slot + 14 stays below 256
  localparam int unsigned TWO_W  = CELL_ID_W + 1;
  localparam int unsigned PROD_W = A_W + TWO_W;

  logic              valid_r;
  job_t              job_r;
  job_t              job_nxt;
  logic [A_W-1:0]    a_val;
  logic [TWO_W-1:0]  two_n1;
  logic [PROD_W-1:0] prod;
  logic              accept;

  assign in_ready = !valid_r || job_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // 7*(slot+1) + sym + 1 with sym = 5 + ref_symbol
    a_val  = A_W'({in_data.slot_number, 3'b000}) - A_W'(in_data.slot_number)
           + A_W'(SYM_BASE) + A_W'(in_data.ref_symbol);
    two_n1 = {cell_id, 1'b1};
    prod   = PROD_W'(a_val) * PROD_W'(two_n1);
    job_nxt.slot_number = in_data.slot_number;
    job_nxt.ref_symbol  = in_data.ref_symbol;
    // 1024*A*(2N+1) + (2N+1): low ten bits never carry
    job_nxt.seed = SEED_W'({prod, two_n1});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (accept) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = valid_r;
  assign job       = job_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !job_ready) |=> (valid_r && $stable(job_r)))
    else $error("front stage dropped or changed a stalled request");

endmodule

>>> hdl/nrs_fifo.sv
// ----------------------------------------------------------------------------
// nrs_fifo
// Small request queue between intake and pilot expansion.
// ----------------------------------------------------------------------------
module nrs_fifo import nrs_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_nxt;
  logic          push;
  logic          pop;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue occupancy did not track a push");

endmodule

>>> hdl/nrs_back.sv
// ----------------------------------------------------------------------------
// nrs_back
// Pilot expansion: jumps the Gold sequence ahead in one GF(2) step and emits
// the two QPSK pilots of a request through an output register.
// ----------------------------------------------------------------------------
module nrs_back import nrs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam logic [3:0] X1_BITS = x1_tail(GOLD_SKIP);
  localparam logic [3:0][SEED_W-1:0] X2_MASK = {
    x2_mask(GOLD_SKIP + 3), x2_mask(GOLD_SKIP + 2),
    x2_mask(GOLD_SKIP + 1), x2_mask(GOLD_SKIP)
  };

  logic       out_valid_r;
  out_t       out_r;
  logic       pend_r;       // second pilot waits in pend_data_r
  out_t       pend_data_r;
  logic [3:0] gold;
  logic       out_free;
  logic       take;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      gold[k] = X1_BITS[k] ^ (^(job.seed & X2_MASK[k]));
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign take      = out_free && !pend_r && job_valid;
  assign job_ready = out_free && !pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (out_free) begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else begin
        out_valid_r <= job_valid;
        pend_r      <= job_valid;
      end
    end
    if (out_free && pend_r) begin
      out_r <= pend_data_r;
    end else if (take) begin
      out_r.pilot_index   <= 1'b0;
      out_r.real_negative <= gold[0];
      out_r.imag_negative <= gold[1];
      out_r.slot_echo     <= job.slot_number;
      out_r.symbol_echo   <= job.ref_symbol;
      out_r.last          <= 1'b0;
      pend_data_r.pilot_index   <= 1'b1;
      pend_data_r.real_negative <= gold[2];
      pend_data_r.imag_negative <= gold[3];
      pend_data_r.slot_echo     <= job.slot_number;
      pend_data_r.symbol_echo   <= job.ref_symbol;
      pend_data_r.last          <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_pend_first: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (out_valid_r && !out_r.last && !out_r.pilot_index))
    else $error("second pilot pending without first pilot on output");

  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !out_r.last)
      |=> (out_valid_r && out_r.last && out_r.pilot_index))
    else $error("first pilot not followed by second pilot");

endmodule

>>> hdl/nbiot_nrs_pilot_generator_core.sv
// ----------------------------------------------------------------------------
// nbiot_nrs_pilot_generator_core
// NB-IoT NRS pilot generator: per request (slot, reference symbol) emits the
// two QPSK pilot sign pairs of the 3GPP Gold sequence for the set cell id.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in_     | input     | in_valid / in_ready  | in_data  (in_t)
//   out_    | output    | out_valid/ out_ready | out_data (out_t), 2 per item
//   cfg_    | input     | cfg_valid/ cfg_ready | cfg_data (cell id, 9 bits)
//
// Path from request acceptance to the first pilot: seed register, queue,
// output register; the second pilot follows from a holding register.
// Sustained rate: the output register delivers one pilot per cycle while
// out_ready is high, and each request takes two pilots. Requests are taken
// every cycle until the request queue fills. Synchronous active-low reset
// clears all control state; cfg_ready is always high.
// ----------------------------------------------------------------------------
module nbiot_nrs_pilot_generator_core import nrs_pkg::*; #(
  parameter int unsigned QUEUE_ENTRIES = QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CELL_ID_W-1:0] cfg_data
);

  logic [CELL_ID_W-1:0] cell_id_r;
  logic                 fq_valid;
  logic                 fq_ready;
  job_t                 fq_job;
  logic                 qb_valid;
  logic                 qb_ready;
  job_t                 qb_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_id_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cell_id_r <= cfg_data;
    end
  end

  nrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cell_id   (cell_id_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  nrs_fifo #(
    .DEPTH (QUEUE_ENTRIES)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_job),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_job)
  );

  nrs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
